// ===== hw/rtl/mwcp_pkg.sv =====
// Package for the lag-3 multiply-with-carry generator.
// Holds the sequencer state type, the item kinds and the hash and multiplier constants.
// No dependencies.
`default_nettype none

package mwcp_pkg;

    typedef enum logic [1:0] {
        KIND_DRAW = 2'd0,
        KIND_SEED = 2'd1,
        KIND_LOAD = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SADD,
        ST_SMUL,
        ST_SACC,
        ST_DMUL,
        ST_DADD,
        ST_ROT
    } t_state;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned OUT_W  = 64;
    localparam int unsigned ROT_AMT = 13;

    localparam logic [WORD_W-1:0] MWC_MULT = 32'd4293666429;
    localparam logic [WORD_W-1:0] HK1      = 32'd4110542893;
    localparam logic [WORD_W-1:0] HK2      = 32'd3667735229;
    localparam logic [WORD_W-1:0] HK3      = 32'd4068774709;
    localparam logic [WORD_W-1:0] HK4      = 32'd3322924477;
    localparam logic [WORD_W-1:0] MASK31   = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] MASK30   = 32'h3FFF_FFFF;

    // Multiplier of seed hash round r
    function automatic logic [WORD_W-1:0] seed_mul(input logic [1:0] r);
        logic [WORD_W-1:0] k;
        case (r)
            2'd0:    k = HK2;
            2'd1:    k = HK3;
            2'd2:    k = HK4;
            default: k = HK1;
        endcase
        return k;
    endfunction

    // Addend of seed hash round r
    function automatic logic [WORD_W-1:0] seed_add(input logic [1:0] r);
        logic [WORD_W-1:0] k;
        case (r)
            2'd0:    k = HK3;
            2'd1:    k = HK4;
            2'd2:    k = HK1;
            default: k = HK2;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mwc_lag3_rotate_prng_unit.sv =====
// Top level of the lag-3 multiply-with-carry generator with rotate-and-add output.
// One shared 32x32 multiplier under a small sequencer; output register toward the master side.
// Depends on mwcp_pkg.
`default_nettype none

// Lag-3 multiply-with-carry generator, base 2^32. Each transaction on the slave
// side carries a kind in tuser: a draw returns one 64-bit value on the master
// side, a seed hashes the seed through four multiply-add rounds and then runs
// four silent draws, a load writes one state word. Kind 3 is dropped. State
// resets to zero, so every draw returns zero until the generator is seeded or
// loaded. A load or an unused kind needs only the accept step; a draw passes
// through accept, multiply, carry add and rotate-add into the output register;
// a seed passes through accept, four hash rounds of add, multiply and
// accumulate, and four draws of multiply and carry add. Every hash round and
// every draw passes through the single multiplier once, with a register after
// it. The slave side is ready only while the sequencer is idle; a finished
// value waits in the output register while the next transaction is taken, and
// the sequencer holds in its last step only when that register is still full.
module mwc_lag3_rotate_prng_unit
    import mwcp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata, low bit up: seed[31:0], word_index[33:32], word_value[65:34], zero pad[71:66]
    input  wire logic [71:0] s_axis_tdata,
    // tuser: kind[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: value[63:0]
    output logic [63:0]      m_axis_tdata
);

    // Sequencer
    t_state r_state;
    t_state n_state;

    // Generator state: lag words oldest first, then carry
    logic [WORD_W-1:0] r_lag [3];
    logic [WORD_W-1:0] r_carry;

    // Work registers
    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_prev;
    logic [WORD_W-1:0] r_opa;
    logic [OUT_W-1:0]  r_prod;
    logic [OUT_W-1:0]  r_x;
    logic [1:0]        r_cnt;
    logic              r_emit;

    // Output register
    logic [OUT_W-1:0]  r_out;
    logic              r_out_valid;

    // Control from the output decode
    logic              s_accept;
    logic              out_load;

    // Slave-side fields
    t_kind             in_kind;
    logic [WORD_W-1:0] in_seed;
    logic [1:0]        in_index;
    logic [WORD_W-1:0] in_value;

    // Shared multiplier
    logic [WORD_W-1:0] mul_a;
    logic [WORD_W-1:0] mul_b;
    logic [OUT_W-1:0]  mul_prod;

    logic [OUT_W-1:0]  draw_x;
    logic [WORD_W-1:0] hash_t;

    assign in_kind  = t_kind'(s_axis_tuser);
    assign in_seed  = s_axis_tdata[31:0];
    assign in_index = s_axis_tdata[33:32];
    assign in_value = s_axis_tdata[65:34];

    assign mul_a    = (r_state == ST_DMUL) ? r_lag[0] : r_opa;
    assign mul_b    = (r_state == ST_DMUL) ? MWC_MULT : seed_mul(r_cnt);
    assign mul_prod = {32'd0, mul_a} * {32'd0, mul_b};

    assign draw_x = r_prod + {32'd0, r_carry};
    assign hash_t = r_prod[WORD_W-1:0] + seed_add(r_cnt);

    // Output decode
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        s_accept      = s_axis_tvalid && (r_state == ST_IDLE);
        out_load      = (r_state == ST_ROT) && (!r_out_valid || m_axis_tready);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    if (in_kind == KIND_DRAW) begin
                        n_state = ST_DMUL;
                    end else if (in_kind == KIND_SEED) begin
                        n_state = ST_SADD;
                    end
                end
            end
            ST_SADD: n_state = ST_SMUL;
            ST_SMUL: n_state = ST_SACC;
            ST_SACC: n_state = (r_cnt == 2'd3) ? ST_DMUL : ST_SADD;
            ST_DMUL: n_state = ST_DADD;
            ST_DADD: begin
                if (r_emit) begin
                    n_state = ST_ROT;
                end else if (r_cnt == 2'd0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_DMUL;
                end
            end
            ST_ROT:  n_state = out_load ? ST_IDLE : ST_ROT;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_lag[0]    <= '0;
            r_lag[1]    <= '0;
            r_lag[2]    <= '0;
            r_carry     <= '0;
            r_cnt       <= '0;
            r_emit      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= out_load || (r_out_valid && !m_axis_tready);

            case (r_state)
                ST_IDLE: begin
                    r_cnt  <= 2'd0;
                    r_emit <= (in_kind == KIND_DRAW);
                    // Load writes straight into the state
                    if (s_accept && (in_kind == KIND_LOAD)) begin
                        case (in_index)
                            2'd0:    r_lag[0] <= in_value;
                            2'd1:    r_lag[1] <= in_value;
                            2'd2:    r_lag[2] <= in_value;
                            default: r_carry  <= in_value;
                        endcase
                    end
                end
                ST_SACC: begin
                    // Mask each hashed word as it lands
                    case (r_cnt)
                        2'd0:    r_lag[0] <= hash_t & MASK31;
                        2'd1:    r_lag[1] <= hash_t & MASK31;
                        2'd2:    r_lag[2] <= hash_t & MASK31;
                        default: r_carry  <= hash_t & MASK30;
                    endcase
                    // After the last round, r_cnt stays 3 and counts the silent draws
                    if (r_cnt != 2'd3) begin
                        r_cnt <= r_cnt + 2'd1;
                    end
                end
                ST_DADD: begin
                    // Shift lags, store low half as newest word and high half as carry
                    r_lag[0] <= r_lag[1];
                    r_lag[1] <= r_lag[2];
                    r_lag[2] <= draw_x[WORD_W-1:0];
                    r_carry  <= draw_x[OUT_W-1:WORD_W];
                    if (!r_emit && (r_cnt != 2'd0)) begin
                        r_cnt <= r_cnt - 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_seed <= in_seed;
        end
        if (r_state == ST_SADD) begin
            r_opa <= r_seed + ((r_cnt == 2'd0) ? HK1 : r_prev);
        end
        if ((r_state == ST_SMUL) || (r_state == ST_DMUL)) begin
            r_prod <= mul_prod;
        end
        if (r_state == ST_SACC) begin
            r_prev <= hash_t;
        end
        if (r_state == ST_DADD) begin
            r_x <= draw_x;
        end
        if (out_load) begin
            r_out <= r_x + {r_x[OUT_W-ROT_AMT-1:0], r_x[OUT_W-1:OUT_W-ROT_AMT]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/mwcp_chk.sv =====
// Port-level checker for the lag-3 multiply-with-carry generator, and its bind.
// Watches only the top level's ports.
// Depends on mwc_lag3_rotate_prng_unit and mwcp_pkg.
`default_nettype none

module mwcp_chk
    import mwcp_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [71:0] s_axis_tdata,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [63:0] m_axis_tdata
);

    logic s_fire;
    assign s_fire = s_axis_tvalid && s_axis_tready;

    // Hold a stalled result and its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Draws and seeds keep the sequencer busy after their accept cycle
    a_busy_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && ((s_axis_tuser == KIND_DRAW) || (s_axis_tuser == KIND_SEED))
        |=> !s_axis_tready)
        else $error("ready right after draw or seed");

    // Loads and unused kinds finish in the accept cycle
    a_ready_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire && ((s_axis_tuser == KIND_LOAD) || (s_axis_tuser == KIND_NONE))
        |=> s_axis_tready)
        else $error("not ready after load");

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    logic unused_data;
    assign unused_data = ^s_axis_tdata;

endmodule

bind mwc_lag3_rotate_prng_unit mwcp_chk u_mwcp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
